/* rtl/rci_pkg.sv */
package rci_pkg;

    localparam int UNIT_BITS = 30;
    localparam int NORM_BITS = 31;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_RADIUS   = 2'd2
    } cfg_idx_t;

endpackage

/* rtl/rci_sqrt.sv */
module rci_sqrt #(
    parameter int RES_BITS  = 32,
    parameter int SIDE_BITS = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [2*RES_BITS-1:0]   in_rad,
    input  logic [SIDE_BITS-1:0]    in_side,
    output logic                    out_valid,
    output logic [RES_BITS-1:0]     out_root,
    output logic [SIDE_BITS-1:0]    out_side
);

    localparam int RB = RES_BITS;
    localparam int RW = RES_BITS + 2;

    logic [RW-1:0]        rem_reg  [RB];
    logic [RB-1:0]        root_reg [RB];
    logic [2*RB-1:0]      rad_reg  [RB];
    logic [SIDE_BITS-1:0] side_reg [RB];
    logic                 vld_reg  [RB];

    // One result bit per stage, two radicand bits consumed per stage.
    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [RW-1:0]        rem_in;
        logic [RB-1:0]        root_in;
        logic [2*RB-1:0]      rad_in;
        logic [SIDE_BITS-1:0] side_in;
        logic                 v_in;
        logic [RW-1:0]        rem_sh;
        logic [RW-1:0]        trial;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign side_in = in_side;
            assign v_in    = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_in = side_reg[k-1];
            assign v_in    = vld_reg[k-1];
        end

        assign rem_sh = {rem_in[RB-1:0], rad_in[2*RB-1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rem_sh >= trial)
            begin
                rem_reg[k]  <= rem_sh - trial;
                root_reg[k] <= {root_in[RB-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k]  <= rem_sh;
                root_reg[k] <= {root_in[RB-2:0], 1'b0};
            end
            rad_reg[k]  <= rad_in << 2;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = vld_reg[RB-1];
    assign out_root  = root_reg[RB-1];
    assign out_side  = side_reg[RB-1];

endmodule

/* rtl/ray_circle_intersect_core.sv */
// Throughput: one word per cycle; the two square roots and the divider are
// pipelined one result bit per stage, so every stage takes a new word each cycle.
// busy stays low, and results leave on done for one cycle; the receiver cannot stall.
// Reset clears the valid bits and the circle registers to zero.
module ray_circle_intersect_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rci_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_WIDTH-1:0]         cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_WIDTH-1:0]  origin_x,
    input  logic signed [COORD_WIDTH-1:0]  origin_y,
    input  logic signed [COORD_WIDTH-1:0]  dir_x,
    input  logic signed [COORD_WIDTH-1:0]  dir_y,
    output logic                           done,
    output logic                           hit,
    output logic signed [COORD_WIDTH-1:0]  t_hit,
    output logic signed [COORD_WIDTH-1:0]  normal_x,
    output logic signed [COORD_WIDTH-1:0]  normal_y
);

    localparam int CW    = COORD_WIDTH;
    localparam int UB    = rci_pkg::UNIT_BITS;
    localparam int NB    = rci_pkg::NORM_BITS;
    localparam int WW    = CW + 1;
    localparam int NSTEP = $clog2(CW);
    localparam int LB    = NB + 1;
    localparam int DB    = NB;
    localparam int NW    = NB + UB + 1;
    localparam int UW    = NB + 1;
    localparam int PW    = WW + UW;
    localparam int PPW   = PW + 1 - UB;
    localparam int HW    = 2 * PPW;
    localparam int QB    = CW - 1;
    localparam int QW    = 2 * QB;
    localparam int CMPW  = (HW > QW) ? HW : QW;
    localparam int TW    = (PPW + 1 > QB + 2) ? PPW + 1 : QB + 2;
    localparam int TPW   = TW + UW;
    localparam int OFW   = TPW + 1 - UB;
    localparam int NXW   = OFW + 1;
    localparam int LAT   = 11 + NSTEP + LB + DB + QB;

    localparam logic signed [PW:0]    HALF_P = (PW + 1)'(1) <<< (UB - 1);
    localparam logic signed [TPW:0]   HALF_T = (TPW + 1)'(1) <<< (UB - 1);
    localparam logic signed [NXW-1:0] SMAX   = NXW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [NXW-1:0] SMIN   = -SMAX - NXW'(1);

    typedef struct packed {
        logic signed [WW-1:0] wx;
        logic signed [WW-1:0] wy;
        logic                 sx;
        logic                 sy;
        logic                 zero;
    } ray_t;

    typedef struct packed {
        logic signed [WW-1:0]  wx;
        logic signed [WW-1:0]  wy;
        logic signed [UW-1:0]  ux;
        logic signed [UW-1:0]  uy;
        logic signed [PPW-1:0] p;
        logic                  tangent;
        logic                  hit;
    } sol_t;

    localparam int SW1 = 2 * NB + $bits(ray_t);
    localparam int SW2 = $bits(sol_t);

    function automatic logic signed [CW-1:0] sat_fn(input logic signed [NXW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SMAX)
        begin
            r = SMAX[CW-1:0];
        end
        else if (v < SMIN)
        begin
            r = SMIN[CW-1:0];
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    assign busy = 1'b0;

    // Circle registers.
    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic [CW-2:0]        rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            rad_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (rci_pkg::cfg_idx_t'(cfg_index))
                rci_pkg::CFG_CENTER_X: cx_reg  <= cfg_data;
                rci_pkg::CFG_CENTER_Y: cy_reg  <= cfg_data;
                rci_pkg::CFG_RADIUS:   rad_reg <= cfg_data[CW-2:0];
                default: ;
            endcase
        end
    end

    // Input stage: offset from the center and direction magnitudes.
    logic          s0_vld_reg;
    logic [CW-1:0] s0_ax_reg;
    logic [CW-1:0] s0_ay_reg;
    ray_t          s0_rs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_ax_reg         <= dir_x[CW-1] ? CW'(-dir_x) : dir_x;
        s0_ay_reg         <= dir_y[CW-1] ? CW'(-dir_y) : dir_y;
        s0_rs_reg.wx      <= $signed({origin_x[CW-1], origin_x}) - $signed({cx_reg[CW-1], cx_reg});
        s0_rs_reg.wy      <= $signed({origin_y[CW-1], origin_y}) - $signed({cy_reg[CW-1], cy_reg});
        s0_rs_reg.sx      <= dir_x[CW-1];
        s0_rs_reg.sy      <= dir_y[CW-1];
        s0_rs_reg.zero    <= (dir_x == '0) && (dir_y == '0);
    end

    // Normalization: a binary shift search, one shift distance per stage.
    logic          nm_vld_reg [NSTEP];
    logic [CW-1:0] nm_ax_reg  [NSTEP];
    logic [CW-1:0] nm_ay_reg  [NSTEP];
    ray_t          nm_rs_reg  [NSTEP];

    for (genvar k = 0; k < NSTEP; k++) begin : g_norm
        localparam int SH = 1 << (NSTEP - 1 - k);
        logic          v_in;
        logic [CW-1:0] ax_in;
        logic [CW-1:0] ay_in;
        logic [CW-1:0] orm;
        ray_t          rs_in;

        if (k == 0) begin : g_first
            assign v_in  = s0_vld_reg;
            assign ax_in = s0_ax_reg;
            assign ay_in = s0_ay_reg;
            assign rs_in = s0_rs_reg;
        end else begin : g_next
            assign v_in  = nm_vld_reg[k-1];
            assign ax_in = nm_ax_reg[k-1];
            assign ay_in = nm_ay_reg[k-1];
            assign rs_in = nm_rs_reg[k-1];
        end

        assign orm = ax_in | ay_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                nm_vld_reg[k] <= 1'b0;
            end
            else
            begin
                nm_vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (orm[CW-1 -: SH] == '0)
            begin
                nm_ax_reg[k] <= ax_in << SH;
                nm_ay_reg[k] <= ay_in << SH;
            end
            else
            begin
                nm_ax_reg[k] <= ax_in;
                nm_ay_reg[k] <= ay_in;
            end
            nm_rs_reg[k] <= rs_in;
        end
    end

    logic [NB-1:0] nx_val;
    logic [NB-1:0] ny_val;

    if (CW >= NB) begin : g_top
        assign nx_val = nm_ax_reg[NSTEP-1][CW-1 -: NB];
        assign ny_val = nm_ay_reg[NSTEP-1][CW-1 -: NB];
    end else begin : g_pad
        assign nx_val = {nm_ax_reg[NSTEP-1], {(NB - CW){1'b0}}};
        assign ny_val = {nm_ay_reg[NSTEP-1], {(NB - CW){1'b0}}};
    end

    // Squared length of the normalized direction.
    logic            sq_vld_reg;
    logic [2*NB-1:0] sq_xx_reg;
    logic [2*NB-1:0] sq_yy_reg;
    logic [NB-1:0]   sq_x_reg;
    logic [NB-1:0]   sq_y_reg;
    ray_t            sq_rs_reg;
    logic            su_vld_reg;
    logic [2*NB:0]   su_s_reg;
    logic [NB-1:0]   su_x_reg;
    logic [NB-1:0]   su_y_reg;
    ray_t            su_rs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
            su_vld_reg <= 1'b0;
        end
        else
        begin
            sq_vld_reg <= nm_vld_reg[NSTEP-1];
            su_vld_reg <= sq_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_xx_reg <= nx_val * nx_val;
        sq_yy_reg <= ny_val * ny_val;
        sq_x_reg  <= nx_val;
        sq_y_reg  <= ny_val;
        sq_rs_reg <= nm_rs_reg[NSTEP-1];
        su_s_reg  <= {1'b0, sq_xx_reg} + {1'b0, sq_yy_reg};
        su_x_reg  <= sq_x_reg;
        su_y_reg  <= sq_y_reg;
        su_rs_reg <= sq_rs_reg;
    end

    logic           l_vld;
    logic [LB-1:0]  l_len;
    logic [SW1-1:0] l_side;
    logic [NB-1:0]  l_x;
    logic [NB-1:0]  l_y;
    ray_t           l_rs;

    rci_sqrt #(
        .RES_BITS  (LB),
        .SIDE_BITS (SW1)
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (su_vld_reg),
        .in_rad    ({{(2 * LB - 2 * NB - 1){1'b0}}, su_s_reg}),
        .in_side   ({su_x_reg, su_y_reg, su_rs_reg}),
        .out_valid (l_vld),
        .out_root  (l_len),
        .out_side  (l_side)
    );

    assign {l_x, l_y, l_rs} = l_side;

    // Unit vector: two restoring dividers sharing the length, one quotient bit per stage.
    logic [NW-1:0] num_x;
    logic [NW-1:0] num_y;

    assign num_x = {1'b0, l_x, {UB{1'b0}}} + NW'(l_len >> 1);
    assign num_y = {1'b0, l_y, {UB{1'b0}}} + NW'(l_len >> 1);

    logic          dv_vld_reg [DB];
    logic [LB-1:0] dv_len_reg [DB];
    logic [LB-1:0] dv_rx_reg  [DB];
    logic [LB-1:0] dv_ry_reg  [DB];
    logic [DB-1:0] dv_lx_reg  [DB];
    logic [DB-1:0] dv_ly_reg  [DB];
    logic [DB-1:0] dv_qx_reg  [DB];
    logic [DB-1:0] dv_qy_reg  [DB];
    ray_t          dv_rs_reg  [DB];

    for (genvar k = 0; k < DB; k++) begin : g_div
        logic          v_in;
        logic [LB-1:0] len_in;
        logic [LB-1:0] rx_in;
        logic [LB-1:0] ry_in;
        logic [DB-1:0] lx_in;
        logic [DB-1:0] ly_in;
        logic [DB-1:0] qx_in;
        logic [DB-1:0] qy_in;
        ray_t          rs_in;
        logic [LB:0]   rx_sh;
        logic [LB:0]   ry_sh;

        if (k == 0) begin : g_first
            assign v_in   = l_vld;
            assign len_in = l_len;
            assign rx_in  = LB'(num_x[NW-1:DB]);
            assign ry_in  = LB'(num_y[NW-1:DB]);
            assign lx_in  = num_x[DB-1:0];
            assign ly_in  = num_y[DB-1:0];
            assign qx_in  = '0;
            assign qy_in  = '0;
            assign rs_in  = l_rs;
        end else begin : g_next
            assign v_in   = dv_vld_reg[k-1];
            assign len_in = dv_len_reg[k-1];
            assign rx_in  = dv_rx_reg[k-1];
            assign ry_in  = dv_ry_reg[k-1];
            assign lx_in  = dv_lx_reg[k-1];
            assign ly_in  = dv_ly_reg[k-1];
            assign qx_in  = dv_qx_reg[k-1];
            assign qy_in  = dv_qy_reg[k-1];
            assign rs_in  = dv_rs_reg[k-1];
        end

        assign rx_sh = {rx_in, lx_in[DB-1]};
        assign ry_sh = {ry_in, ly_in[DB-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
            else
            begin
                dv_vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rx_sh >= {1'b0, len_in})
            begin
                dv_rx_reg[k] <= LB'(rx_sh - {1'b0, len_in});
                dv_qx_reg[k] <= {qx_in[DB-2:0], 1'b1};
            end
            else
            begin
                dv_rx_reg[k] <= rx_sh[LB-1:0];
                dv_qx_reg[k] <= {qx_in[DB-2:0], 1'b0};
            end
            if (ry_sh >= {1'b0, len_in})
            begin
                dv_ry_reg[k] <= LB'(ry_sh - {1'b0, len_in});
                dv_qy_reg[k] <= {qy_in[DB-2:0], 1'b1};
            end
            else
            begin
                dv_ry_reg[k] <= ry_sh[LB-1:0];
                dv_qy_reg[k] <= {qy_in[DB-2:0], 1'b0};
            end
            dv_lx_reg[k]  <= lx_in << 1;
            dv_ly_reg[k]  <= ly_in << 1;
            dv_len_reg[k] <= len_in;
            dv_rs_reg[k]  <= rs_in;
        end
    end

    ray_t                 d_rs;
    logic signed [UW-1:0] d_ux;
    logic signed [UW-1:0] d_uy;

    assign d_rs = dv_rs_reg[DB-1];
    assign d_ux = d_rs.sx ? -$signed({1'b0, dv_qx_reg[DB-1]}) : $signed({1'b0, dv_qx_reg[DB-1]});
    assign d_uy = d_rs.sy ? -$signed({1'b0, dv_qy_reg[DB-1]}) : $signed({1'b0, dv_qy_reg[DB-1]});

    // Dot and cross products against the unit direction.
    logic                  pr_vld_reg;
    logic signed [PW-1:0]  pr_a_reg;
    logic signed [PW-1:0]  pr_b_reg;
    logic signed [PW-1:0]  pr_c_reg;
    logic signed [PW-1:0]  pr_d_reg;
    logic signed [WW-1:0]  pr_wx_reg;
    logic signed [WW-1:0]  pr_wy_reg;
    logic signed [UW-1:0]  pr_ux_reg;
    logic signed [UW-1:0]  pr_uy_reg;
    logic                  pr_zero_reg;

    logic                  ph_vld_reg;
    logic signed [PPW-1:0] ph_p_reg;
    logic signed [PPW-1:0] ph_h_reg;
    logic signed [WW-1:0]  ph_wx_reg;
    logic signed [WW-1:0]  ph_wy_reg;
    logic signed [UW-1:0]  ph_ux_reg;
    logic signed [UW-1:0]  ph_uy_reg;
    logic                  ph_zero_reg;

    logic                  hq_vld_reg;
    logic [HW-1:0]         hq_h2_reg;
    logic [QW-1:0]         hq_r2_reg;
    logic signed [PPW-1:0] hq_p_reg;
    logic signed [WW-1:0]  hq_wx_reg;
    logic signed [WW-1:0]  hq_wy_reg;
    logic signed [UW-1:0]  hq_ux_reg;
    logic signed [UW-1:0]  hq_uy_reg;
    logic                  hq_zero_reg;

    logic                  qd_vld_reg;
    logic [QW-1:0]         qd_q_reg;
    sol_t                  qd_so_reg;

    logic signed [PW:0]    p_sum;
    logic signed [PW:0]    h_sum;
    logic signed [HW-1:0]  h_sq;
    logic                  miss;
    logic [QW-1:0]         q_val;

    assign p_sum = $signed({pr_a_reg[PW-1], pr_a_reg}) + $signed({pr_b_reg[PW-1], pr_b_reg}) + HALF_P;
    assign h_sum = $signed({pr_c_reg[PW-1], pr_c_reg}) - $signed({pr_d_reg[PW-1], pr_d_reg}) + HALF_P;
    assign h_sq  = ph_h_reg * ph_h_reg;
    assign miss  = CMPW'(hq_r2_reg) < CMPW'(hq_h2_reg);
    assign q_val = QW'(hq_r2_reg - hq_h2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_vld_reg <= 1'b0;
            ph_vld_reg <= 1'b0;
            hq_vld_reg <= 1'b0;
            qd_vld_reg <= 1'b0;
        end
        else
        begin
            pr_vld_reg <= dv_vld_reg[DB-1];
            ph_vld_reg <= pr_vld_reg;
            hq_vld_reg <= ph_vld_reg;
            qd_vld_reg <= hq_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pr_a_reg    <= d_rs.wx * d_ux;
        pr_b_reg    <= d_rs.wy * d_uy;
        pr_c_reg    <= d_rs.wx * d_uy;
        pr_d_reg    <= d_rs.wy * d_ux;
        pr_wx_reg   <= d_rs.wx;
        pr_wy_reg   <= d_rs.wy;
        pr_ux_reg   <= d_ux;
        pr_uy_reg   <= d_uy;
        pr_zero_reg <= d_rs.zero;

        ph_p_reg    <= p_sum[PW:UB];
        ph_h_reg    <= h_sum[PW:UB];
        ph_wx_reg   <= pr_wx_reg;
        ph_wy_reg   <= pr_wy_reg;
        ph_ux_reg   <= pr_ux_reg;
        ph_uy_reg   <= pr_uy_reg;
        ph_zero_reg <= pr_zero_reg;

        hq_h2_reg   <= h_sq;
        hq_r2_reg   <= rad_reg * rad_reg;
        hq_p_reg    <= ph_p_reg;
        hq_wx_reg   <= ph_wx_reg;
        hq_wy_reg   <= ph_wy_reg;
        hq_ux_reg   <= ph_ux_reg;
        hq_uy_reg   <= ph_uy_reg;
        hq_zero_reg <= ph_zero_reg;

        qd_q_reg          <= q_val;
        qd_so_reg.wx      <= hq_wx_reg;
        qd_so_reg.wy      <= hq_wy_reg;
        qd_so_reg.ux      <= hq_ux_reg;
        qd_so_reg.uy      <= hq_uy_reg;
        qd_so_reg.p       <= hq_p_reg;
        qd_so_reg.tangent <= (q_val >> (2 * FRAC_BITS - 2)) == '0;
        qd_so_reg.hit     <= !hq_zero_reg && !miss;
    end

    logic           r_vld;
    logic [QB-1:0]  r_root;
    logic [SW2-1:0] r_side;
    sol_t           r_so;

    rci_sqrt #(
        .RES_BITS  (QB),
        .SIDE_BITS (SW2)
    ) u_disc_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qd_vld_reg),
        .in_rad    (qd_q_reg),
        .in_side   (qd_so_reg),
        .out_valid (r_vld),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    assign r_so = r_side;

    // Nearer root, then the hit point relative to the center.
    logic signed [TW-1:0]  t_val;

    assign t_val = -TW'(r_so.p) - (r_so.tangent ? TW'(0) : $signed(TW'(r_root)));

    logic                  tt_vld_reg;
    logic signed [TW-1:0]  tt_t_reg;
    logic signed [WW-1:0]  tt_wx_reg;
    logic signed [WW-1:0]  tt_wy_reg;
    logic signed [UW-1:0]  tt_ux_reg;
    logic signed [UW-1:0]  tt_uy_reg;
    logic                  tt_hit_reg;

    logic                  tu_vld_reg;
    logic signed [TPW-1:0] tu_x_reg;
    logic signed [TPW-1:0] tu_y_reg;
    logic signed [TW-1:0]  tu_t_reg;
    logic signed [WW-1:0]  tu_wx_reg;
    logic signed [WW-1:0]  tu_wy_reg;
    logic                  tu_hit_reg;

    logic                  of_vld_reg;
    logic signed [OFW-1:0] of_x_reg;
    logic signed [OFW-1:0] of_y_reg;
    logic signed [TW-1:0]  of_t_reg;
    logic signed [WW-1:0]  of_wx_reg;
    logic signed [WW-1:0]  of_wy_reg;
    logic                  of_hit_reg;

    logic                  done_reg;
    logic                  hit_reg;
    logic signed [CW-1:0]  t_hit_reg;
    logic signed [CW-1:0]  normal_x_reg;
    logic signed [CW-1:0]  normal_y_reg;

    logic signed [TPW:0]   ox_sum;
    logic signed [TPW:0]   oy_sum;
    logic signed [NXW-1:0] nx_val_w;
    logic signed [NXW-1:0] ny_val_w;

    assign ox_sum   = $signed({tu_x_reg[TPW-1], tu_x_reg}) + HALF_T;
    assign oy_sum   = $signed({tu_y_reg[TPW-1], tu_y_reg}) + HALF_T;
    assign nx_val_w = NXW'(of_wx_reg) + NXW'(of_x_reg);
    assign ny_val_w = NXW'(of_wy_reg) + NXW'(of_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tt_vld_reg <= 1'b0;
            tu_vld_reg <= 1'b0;
            of_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            tt_vld_reg <= r_vld;
            tu_vld_reg <= tt_vld_reg;
            of_vld_reg <= tu_vld_reg;
            done_reg   <= of_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tt_t_reg   <= t_val;
        tt_wx_reg  <= r_so.wx;
        tt_wy_reg  <= r_so.wy;
        tt_ux_reg  <= r_so.ux;
        tt_uy_reg  <= r_so.uy;
        tt_hit_reg <= r_so.hit;

        tu_x_reg   <= tt_t_reg * tt_ux_reg;
        tu_y_reg   <= tt_t_reg * tt_uy_reg;
        tu_t_reg   <= tt_t_reg;
        tu_wx_reg  <= tt_wx_reg;
        tu_wy_reg  <= tt_wy_reg;
        tu_hit_reg <= tt_hit_reg;

        of_x_reg   <= ox_sum[TPW:UB];
        of_y_reg   <= oy_sum[TPW:UB];
        of_t_reg   <= tu_t_reg;
        of_wx_reg  <= tu_wx_reg;
        of_wy_reg  <= tu_wy_reg;
        of_hit_reg <= tu_hit_reg;

        hit_reg <= of_hit_reg;
        if (of_hit_reg)
        begin
            t_hit_reg    <= sat_fn(NXW'(of_t_reg));
            normal_x_reg <= sat_fn(nx_val_w);
            normal_y_reg <= sat_fn(ny_val_w);
        end
        else
        begin
            t_hit_reg    <= '0;
            normal_x_reg <= '0;
            normal_y_reg <= '0;
        end
    end

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign t_hit    = t_hit_reg;
    assign normal_x = normal_x_reg;
    assign normal_y = normal_y_reg;

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("accepted word did not come out after the pipeline latency");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result word without a matching accepted word");

    a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (start && dir_x == '0 && dir_y == '0) |-> ##LAT (done && !hit))
        else $error("zero direction reported as a hit");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (t_hit == '0 && normal_x == '0 && normal_y == '0))
        else $error("miss carries nonzero fields");
`endif

endmodule
